>>> rtl/core/gtpde_pkg.sv
// ----------------------------------------------------------------------------
// gtpde_pkg: shared types and constants of the downlink encapsulator
// Item layouts, verdict and cause codes, register indexes, header constants.
// ----------------------------------------------------------------------------
package gtpde_pkg;

  // input item, last field (frame_len) in the lowest bits
  typedef struct packed {
    logic [47:0] own_mac;
    logic [47:0] next_hop_mac;
    logic [7:0]  flow_id;
    logic [31:0] peer_address;
    logic [31:0] tunnel_teid;
    logic [1:0]  session_status;
    logic [15:0] inner_total_len;
    logic [31:0] udp_port_pair;
    logic [7:0]  ip_proto;
    logic [7:0]  version_ihl;
    logic [15:0] ether_type;
    logic [15:0] frame_len;
  } in_item_t;

  localparam int unsigned InItemWidth = $bits(in_item_t);
  localparam int unsigned InDataWidth = ((InItemWidth + 7) / 8) * 8;
  localparam int unsigned NumWords    = 8;
  localparam int unsigned WordIdxW    = $clog2(NumWords);
  localparam int unsigned OutUserW    = 8;

  typedef enum logic [1:0] {
    VERDICT_PASS    = 2'd0,
    VERDICT_DROP    = 2'd1,
    VERDICT_FORWARD = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    CAUSE_NONE       = 3'd0,
    CAUSE_SHORT      = 3'd1,
    CAUSE_ALREADY    = 3'd2,
    CAUSE_NO_SESSION = 3'd3,
    CAUSE_INACTIVE   = 3'd4,
    CAUSE_OVERSIZE   = 3'd5,
    CAUSE_NO_SOURCE  = 3'd6
  } cause_t;

  // session lookup status codes
  localparam logic [1:0] SESSION_MISSING = 2'd0;
  localparam logic [1:0] SESSION_ACTIVE  = 2'd2;

  // configuration register indexes
  localparam logic CFG_LINK_MTU       = 1'b0;
  localparam logic CFG_SOURCE_ADDRESS = 1'b1;

  // protocol constants
  localparam logic [15:0] ETH_TYPE_IPV4  = 16'h0800;
  localparam logic [3:0]  IP_VERSION4    = 4'd4;
  localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
  localparam logic [15:0] GTPU_PORT      = 16'd2152;
  localparam logic [15:0] DEFAULT_MTU    = 16'd1500;
  localparam logic [15:0] MIN_FRAME_LEN  = 16'd38;
  localparam logic [7:0]  IP_VER_IHL     = 8'h45;
  localparam logic [7:0]  IP_TTL         = 8'd64;
  localparam logic [7:0]  GTPU_FLAGS     = 8'h34;
  localparam logic [7:0]  GTPU_MSG_GPDU  = 8'hFF;
  localparam logic [7:0]  EXT_PDU_SESS   = 8'h85;
  localparam logic [7:0]  EXT_LEN_ONE    = 8'h01;
  localparam logic [7:0]  QFI_DEFAULT    = 8'd9;
  localparam logic [7:0]  QFI_MASK       = 8'h3F;
  localparam logic [15:0] IP_LEN_ADD     = 16'd44;
  localparam logic [15:0] UDP_LEN_ADD    = 16'd24;
  localparam logic [15:0] GTP_LEN_ADD    = 16'd8;
  // frame_len - 14 + 44
  localparam logic [16:0] FRAME_GROWTH   = 17'd30;

  // one decided frame: verdict, cause and the outer header words
  typedef struct packed {
    verdict_t                   verdict;
    cause_t                     cause;
    logic [NumWords-1:0][63:0]  words;
  } frame_t;

endpackage

>>> rtl/core/gtpde_decide.sv
// ----------------------------------------------------------------------------
// gtpde_decide: verdict and outer header builder
// Checks one frame in priority order and builds the 58-byte outer header.
// ----------------------------------------------------------------------------
module gtpde_decide (
  input  gtpde_pkg::in_item_t item,
  input  logic [15:0]         egress_mtu,
  input  logic [31:0]         source_address,
  output gtpde_pkg::frame_t   frame
);

  localparam int unsigned NumWordsLocal = gtpde_pkg::NumWords;

  logic [3:0]  ihl;
  logic [15:0] port_reach;
  logic        ports_gtp;
  logic        already_gtp;
  logic [15:0] mtu;
  logic [16:0] outer_len;
  logic [15:0] tot_len;
  logic [15:0] udp_len;
  logic [15:0] gtp_len;
  logic [7:0]  qfi;
  logic [19:0] cs_sum;
  logic [16:0] cs_fold1;
  logic [15:0] cs_fold2;
  logic [15:0] cs;
  logic [NumWordsLocal-1:0][63:0] hdr;

  // udp port check, only when the ports lie inside the frame
  assign ihl         = item.version_ihl[3:0];
  assign port_reach  = 16'd18 + {10'd0, ihl, 2'b00};
  assign ports_gtp   = (item.udp_port_pair[15:0] == gtpde_pkg::GTPU_PORT) ||
                       (item.udp_port_pair[31:16] == gtpde_pkg::GTPU_PORT);
  assign already_gtp = (item.ip_proto == gtpde_pkg::IP_PROTO_UDP) && (ihl >= 4'd5) &&
                       (port_reach <= item.frame_len) && ports_gtp;

  // size check against the link mtu
  assign mtu       = (egress_mtu != 16'd0) ? egress_mtu : gtpde_pkg::DEFAULT_MTU;
  assign outer_len = {1'b0, item.frame_len} + gtpde_pkg::FRAME_GROWTH;

  // wrapped length fields and flow id
  assign tot_len = item.inner_total_len + gtpde_pkg::IP_LEN_ADD;
  assign udp_len = item.inner_total_len + gtpde_pkg::UDP_LEN_ADD;
  assign gtp_len = item.inner_total_len + gtpde_pkg::GTP_LEN_ADD;
  assign qfi     = ((item.flow_id != 8'd0) ? item.flow_id : gtpde_pkg::QFI_DEFAULT) &
                   gtpde_pkg::QFI_MASK;

  // ipv4 header checksum, zero words left out of the sum
  assign cs_sum   = {4'd0, gtpde_pkg::IP_VER_IHL, 8'h00} +
                    {4'd0, gtpde_pkg::IP_TTL, gtpde_pkg::IP_PROTO_UDP} +
                    {4'd0, tot_len} +
                    {4'd0, source_address[31:16]} + {4'd0, source_address[15:0]} +
                    {4'd0, item.peer_address[31:16]} + {4'd0, item.peer_address[15:0]};
  assign cs_fold1 = {1'b0, cs_sum[15:0]} + {13'd0, cs_sum[19:16]};
  assign cs_fold2 = cs_fold1[15:0] + {15'd0, cs_fold1[16]};
  assign cs       = ~cs_fold2;

  // outer header, first byte most significant
  assign hdr[0] = {item.next_hop_mac, item.own_mac[47:32]};
  assign hdr[1] = {item.own_mac[31:0], gtpde_pkg::ETH_TYPE_IPV4, gtpde_pkg::IP_VER_IHL, 8'h00};
  assign hdr[2] = {tot_len, 16'h0000, 16'h0000, gtpde_pkg::IP_TTL, gtpde_pkg::IP_PROTO_UDP};
  assign hdr[3] = {cs, source_address, item.peer_address[31:16]};
  assign hdr[4] = {item.peer_address[15:0], gtpde_pkg::GTPU_PORT, gtpde_pkg::GTPU_PORT,
                   udp_len};
  assign hdr[5] = {16'h0000, gtpde_pkg::GTPU_FLAGS, gtpde_pkg::GTPU_MSG_GPDU, gtp_len,
                   item.tunnel_teid[31:16]};
  assign hdr[6] = {item.tunnel_teid[15:0], 24'h000000, gtpde_pkg::EXT_PDU_SESS,
                   gtpde_pkg::EXT_LEN_ONE, 8'h00};
  assign hdr[7] = {qfi, 8'h00, 48'h0};

  // decision in priority order
  always_comb begin
    frame.verdict = gtpde_pkg::VERDICT_DROP;
    frame.cause   = gtpde_pkg::CAUSE_NONE;
    frame.words   = '0;
    if (item.frame_len < gtpde_pkg::MIN_FRAME_LEN) begin
      frame.cause = gtpde_pkg::CAUSE_SHORT;
    end else if ((item.ether_type != gtpde_pkg::ETH_TYPE_IPV4) ||
                 (item.version_ihl[7:4] != gtpde_pkg::IP_VERSION4)) begin
      frame.verdict = gtpde_pkg::VERDICT_PASS;
    end else if (already_gtp) begin
      frame.verdict = gtpde_pkg::VERDICT_PASS;
      frame.cause   = gtpde_pkg::CAUSE_ALREADY;
    end else if (item.session_status == gtpde_pkg::SESSION_MISSING) begin
      frame.cause = gtpde_pkg::CAUSE_NO_SESSION;
    end else if ((item.session_status != gtpde_pkg::SESSION_ACTIVE) ||
                 (item.tunnel_teid == 32'd0)) begin
      frame.cause = gtpde_pkg::CAUSE_INACTIVE;
    end else if (outer_len > {1'b0, mtu}) begin
      frame.cause = gtpde_pkg::CAUSE_OVERSIZE;
    end else if (source_address == 32'd0) begin
      frame.cause = gtpde_pkg::CAUSE_NO_SOURCE;
    end else begin
      frame.verdict = gtpde_pkg::VERDICT_FORWARD;
      frame.words   = hdr;
    end
  end

endmodule

>>> rtl/core/gtpde_serializer.sv
// ----------------------------------------------------------------------------
// gtpde_serializer: frame register and word sequencer
// Holds one decided frame and hands out its words one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module gtpde_serializer (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  gtpde_pkg::frame_t                      frame,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output gtpde_pkg::verdict_t                    out_verdict,
  output gtpde_pkg::cause_t                      out_cause,
  output logic [63:0]                            out_word,
  output logic [gtpde_pkg::WordIdxW-1:0]         out_index,
  output logic                                   out_last
);

  logic                                 fvalid;
  gtpde_pkg::frame_t                    held;
  logic [gtpde_pkg::WordIdxW-1:0]       count;
  logic                                 take;
  logic                                 load;

  // a single item for pass or drop, eight words when forwarding
  assign out_last  = (held.verdict != gtpde_pkg::VERDICT_FORWARD) ||
                     (count == gtpde_pkg::WordIdxW'(gtpde_pkg::NumWords - 1));
  assign out_valid = fvalid;
  assign take      = fvalid && out_ready;
  assign in_ready  = !fvalid || (out_ready && out_last);
  assign load      = in_valid && in_ready;

  assign out_verdict = held.verdict;
  assign out_cause   = held.cause;
  assign out_word    = held.words[count];
  assign out_index   = count;

  // valid flag and word counter
  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
      count  <= '0;
    end else begin
      if (load) begin
        fvalid <= 1'b1;
        count  <= '0;
      end else if (take) begin
        if (out_last) begin
          fvalid <= 1'b0;
        end
        count <= count + 1'b1;
      end
    end
  end

  // frame payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= frame;
    end
  end

endmodule

>>> rtl/core/gtpde_cfg_regs.sv
// ----------------------------------------------------------------------------
// gtpde_cfg_regs: configuration registers
// Link MTU and outer source address, written through the config channel.
// ----------------------------------------------------------------------------
module gtpde_cfg_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  output logic [15:0] egress_mtu,
  output logic [31:0] source_address
);

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      egress_mtu     <= '0;
      source_address <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gtpde_pkg::CFG_LINK_MTU:       egress_mtu     <= cfg_data[15:0];
        gtpde_pkg::CFG_SOURCE_ADDRESS: source_address <= cfg_data;
        default:                       ;
      endcase
    end
  end

endmodule

>>> rtl/core/gtp_downlink_encapsulator_core.sv
// ----------------------------------------------------------------------------
// gtp_downlink_encapsulator_core: GTP-U downlink encapsulation top level
// Decides pass, drop or forward per frame and emits the outer header words.
// ----------------------------------------------------------------------------
// Usage
//   s_* carries one item per frame: parsed header fields plus the session
//   lookup result. m_* returns results: tdata is the header word, tuser
//   holds verdict, cause and word index, tlast marks the final result.
//   cfg_* writes egress_mtu (index 0) and source_address (index 1); write
//   only while no frame is in flight.
// Timing
//   An accepted item is registered in the input register, decided and loaded
//   into the frame register, whose first result is shown from then on. Pass
//   and drop frames give one result and flow at one item per cycle while
//   m_tready is high; a forwarded frame gives eight words, one per cycle
//   while m_tready is high, and the word sequencer takes no new frame
//   until its last word is taken.
// Reset and stall
//   Reset empties both stages and clears the registers to zero (mtu 1500,
//   no source, so encapsulation drops). When m_tready is low the current
// word holds; the input register still takes one more item if it is empty.
// ----------------------------------------------------------------------------
module gtp_downlink_encapsulator_core (
  input  logic                                clk,
  input  logic                                rst,
  // frame_len, ether_type, version_ihl, ip_proto, udp_port_pair,
  // inner_total_len, session_status, tunnel_teid, peer_address, flow_id,
  // next_hop_mac, own_mac, zero padding
  input  logic [gtpde_pkg::InDataWidth-1:0]   s_tdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // header_word
  output logic [63:0]                         m_tdata,
  // verdict, cause, word_index
  output logic [gtpde_pkg::OutUserW-1:0]      m_tuser,
  output logic                                m_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [31:0]                         cfg_data
);

  logic                                ivalid;
  gtpde_pkg::in_item_t                 item;
  logic [15:0]                         egress_mtu;
  logic [31:0]                         source_address;
  gtpde_pkg::frame_t                   frame;
  logic                                ser_ready;
  gtpde_pkg::verdict_t                 out_verdict;
  gtpde_pkg::cause_t                   out_cause;
  logic [gtpde_pkg::WordIdxW-1:0]      out_index;

  gtpde_cfg_regs u_cfg (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .egress_mtu     (egress_mtu),
    .source_address (source_address)
  );

  // input register
  assign s_tready = !ivalid || ser_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ivalid <= 1'b0;
    end else if (s_tready) begin
      ivalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= gtpde_pkg::in_item_t'(s_tdata[gtpde_pkg::InItemWidth-1:0]);
    end
  end

  gtpde_decide u_decide (
    .item           (item),
    .egress_mtu     (egress_mtu),
    .source_address (source_address),
    .frame          (frame)
  );

  gtpde_serializer u_ser (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (ivalid),
    .in_ready    (ser_ready),
    .frame       (frame),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_verdict (out_verdict),
    .out_cause   (out_cause),
    .out_word    (m_tdata),
    .out_index   (out_index),
    .out_last    (m_tlast)
  );

  // result sideband
  assign m_tuser = {out_index, out_cause, out_verdict};

endmodule

>>> rtl/core/gtpde_checker.sv
// ----------------------------------------------------------------------------
// gtpde_checker: port-level checks of the encapsulator
// Word sequencing, last marking and verdict consistency on the result side.
// ----------------------------------------------------------------------------
module gtpde_checker (
  input logic        clk,
  input logic        rst,
  input logic [63:0] m_tdata,
  input logic [7:0]  m_tuser,
  input logic        m_tlast,
  input logic        m_tvalid,
  input logic        m_tready
);

  logic [1:0] verdict;
  logic [2:0] cause;
  logic [2:0] windex;
  logic       fwd;

  assign verdict = m_tuser[1:0];
  assign cause   = m_tuser[4:2];
  assign windex  = m_tuser[7:5];
  assign fwd     = (verdict == gtpde_pkg::VERDICT_FORWARD);

  // words of a forwarded frame come in order without gaps in the index
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
      (m_tvalid && fwd && (windex == $past(windex) + 3'd1)))
    else $error("word index did not advance");

  // a forwarded frame ends exactly at word seven
  a_fwd_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && fwd) |-> (m_tlast == (windex == 3'd7)))
    else $error("last marking wrong on forwarded frame");

  // pass and drop give one empty result
  a_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !fwd) |-> (m_tlast && (windex == 3'd0) && (m_tdata == 64'd0)))
    else $error("pass or drop result malformed");

  // a forwarded frame carries no cause
  a_fwd_cause: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && fwd) |-> (cause == gtpde_pkg::CAUSE_NONE))
    else $error("forwarded frame with a cause");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind gtp_downlink_encapsulator_core gtpde_checker u_gtpde_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

>>> tb/tb_gtp_downlink_encapsulator_core.sv
// ----------------------------------------------------------------------------
// tb_gtp_downlink_encapsulator_core: self-checking bench of the encapsulator
// Drives parsed frame items with random gaps and output stalls. A directed
// table covers every decision and the length and checksum corner cases, and
// random phases under several register settings follow. Each result is
// compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_gtp_downlink_encapsulator_core;
  import gtpde_pkg::*;

  localparam int HalfPeriod   = 10;
  localparam int ResetCycles  = 7;
  localparam int IdleLimit    = 2000;
  localparam int SettleCycles = 6;
  localparam int NumPhases    = 6;
  localparam int PhaseItems   = 55;
  localparam int ResetRows    = 2;

  // session codes the package leaves unnamed
  localparam logic [1:0] SessionInactive = 2'd1;
  localparam logic [1:0] SessionUnlisted = 2'd3;

  // one outer header word or single verdict as the block should return it
  typedef struct {
    verdict_t              verdict;
    cause_t                cause;
    logic [63:0]           word;
    logic [WordIdxW-1:0]   index;
    logic                  last;
  } outer_word_t;

  // directed stimulus row, with the verdict typed in where it is obvious
  typedef struct {
    in_item_t frame;
    bit       typed;
    verdict_t verdict;
    cause_t   cause;
  } directed_row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic [InDataWidth-1:0] s_tdata;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [63:0]            m_tdata;
  logic [OutUserW-1:0]    m_tuser;
  logic                   m_tlast;
  logic                   m_tvalid;
  logic                   m_tready;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic                   cfg_index;
  logic [31:0]            cfg_data;

  // register copies as seen by the block
  logic [15:0]            egress_mtu_q;
  logic [31:0]            source_q;

  outer_word_t            pending_words[$];
  directed_row_t          directed_rows[$];
  int                     mismatch_count = 0;
  int                     idle_cycles = 0;
  bit                     sender_idles;
  bit                     receiver_idles;

  gtp_downlink_encapsulator_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(HalfPeriod) clk = ~clk;

  // decide one frame and queue its verdict or its eight header words
  function automatic void encapsulate_frame(in_item_t f);
    logic [7:0]  hdr [64];
    logic [31:0] sum;
    logic [15:0] tot_len, udp_len, gtp_len, csum;
    logic [7:0]  qfi;
    logic [63:0] w;
    int unsigned ihl, eff_mtu;
    int          i, k;
    verdict_t    verdict;
    cause_t      cause;
    ihl = f.version_ihl[3:0];
    eff_mtu = (egress_mtu_q == 16'd0) ? DEFAULT_MTU : egress_mtu_q;
    verdict = VERDICT_FORWARD;
    cause = CAUSE_NONE;
    if (f.frame_len < MIN_FRAME_LEN) begin
      verdict = VERDICT_DROP;
      cause = CAUSE_SHORT;
    end else if (f.ether_type != ETH_TYPE_IPV4 || f.version_ihl[7:4] != IP_VERSION4) begin
      verdict = VERDICT_PASS;
    end else if (f.ip_proto == IP_PROTO_UDP && ihl >= 5 && 18 + 4 * ihl <= f.frame_len &&
                 (f.udp_port_pair[15:0] == GTPU_PORT || f.udp_port_pair[31:16] == GTPU_PORT)) begin
      verdict = VERDICT_PASS;
      cause = CAUSE_ALREADY;
    end else if (f.session_status == SESSION_MISSING) begin
      verdict = VERDICT_DROP;
      cause = CAUSE_NO_SESSION;
    end else if (f.session_status != SESSION_ACTIVE || f.tunnel_teid == 32'd0) begin
      verdict = VERDICT_DROP;
      cause = CAUSE_INACTIVE;
    end else if (int'(f.frame_len) + 30 > eff_mtu) begin
      verdict = VERDICT_DROP;
      cause = CAUSE_OVERSIZE;
    end else if (source_q == 32'd0) begin
      verdict = VERDICT_DROP;
      cause = CAUSE_NO_SOURCE;
    end
    if (verdict != VERDICT_FORWARD) begin
      pending_words.push_back('{verdict, cause, 64'h0, '0, 1'b1});
      return;
    end

    // outer ethernet, ipv4, udp and gtp-u bytes
    for (i = 0; i < 64; i++) hdr[i] = 8'h00;
    for (i = 0; i < 6; i++) begin
      hdr[i]     = f.next_hop_mac[47 - 8 * i -: 8];
      hdr[6 + i] = f.own_mac[47 - 8 * i -: 8];
    end
    hdr[12] = ETH_TYPE_IPV4[15:8];
    hdr[13] = ETH_TYPE_IPV4[7:0];
    tot_len = f.inner_total_len + IP_LEN_ADD;
    udp_len = f.inner_total_len + UDP_LEN_ADD;
    gtp_len = f.inner_total_len + GTP_LEN_ADD;
    hdr[14] = IP_VER_IHL;
    hdr[16] = tot_len[15:8];
    hdr[17] = tot_len[7:0];
    hdr[22] = IP_TTL;
    hdr[23] = IP_PROTO_UDP;
    for (i = 0; i < 4; i++) begin
      hdr[26 + i] = source_q[31 - 8 * i -: 8];
      hdr[30 + i] = f.peer_address[31 - 8 * i -: 8];
      hdr[46 + i] = f.tunnel_teid[31 - 8 * i -: 8];
    end
    hdr[34] = GTPU_PORT[15:8];
    hdr[35] = GTPU_PORT[7:0];
    hdr[36] = GTPU_PORT[15:8];
    hdr[37] = GTPU_PORT[7:0];
    hdr[38] = udp_len[15:8];
    hdr[39] = udp_len[7:0];
    hdr[42] = GTPU_FLAGS;
    hdr[43] = GTPU_MSG_GPDU;
    hdr[44] = gtp_len[15:8];
    hdr[45] = gtp_len[7:0];
    hdr[53] = EXT_PDU_SESS;
    hdr[54] = EXT_LEN_ONE;
    qfi = (f.flow_id == 8'd0) ? QFI_DEFAULT : f.flow_id;
    hdr[56] = qfi & QFI_MASK;

    // ones' complement sum over the twenty ipv4 header bytes
    sum = 32'd0;
    for (i = 0; i < 10; i++) sum = sum + {hdr[14 + 2 * i], hdr[15 + 2 * i]};
    sum = sum[15:0] + sum[31:16];
    sum = sum[15:0] + sum[31:16];
    csum = ~sum[15:0];
    hdr[24] = csum[15:8];
    hdr[25] = csum[7:0];

    for (k = 0; k < NumWords; k++) begin
      w = 64'h0;
      for (i = 0; i < 8; i++) w = {w[55:0], hdr[8 * k + i]};
      pending_words.push_back('{VERDICT_FORWARD, CAUSE_NONE, w, WordIdxW'(k),
                                k == NumWords - 1});
    end
  endfunction

  // random frame, mostly well formed so that most reach the header builder
  function automatic in_item_t draw_frame();
    in_item_t    f;
    int unsigned eff_mtu, hi, ihl;
    int          kind;
    eff_mtu = (egress_mtu_q == 16'd0) ? DEFAULT_MTU : egress_mtu_q;
    hi = (eff_mtu > 68) ? eff_mtu - 14 : 54;
    if (hi > 65535) hi = 65535;
    kind = $urandom_range(0, 9);
    f.frame_len       = 16'($urandom_range(38, hi));
    f.ether_type      = ETH_TYPE_IPV4;
    f.version_ihl     = {IP_VERSION4, 4'($urandom)};
    f.ip_proto        = $urandom_range(0, 1) ? IP_PROTO_UDP : 8'($urandom);
    f.udp_port_pair   = $urandom;
    f.inner_total_len = 16'($urandom);
    f.session_status  = SESSION_ACTIVE;
    f.tunnel_teid     = $urandom_range(1, 32'hFFFF_FFFF);
    f.peer_address    = $urandom;
    f.flow_id         = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom);
    f.next_hop_mac    = 48'({$urandom, $urandom});
    f.own_mac         = 48'({$urandom, $urandom});
    case (kind)
      6: begin
        // noise in every decision field
        f.frame_len      = 16'($urandom);
        f.ether_type     = 16'($urandom);
        f.version_ihl    = 8'($urandom);
        f.ip_proto       = 8'($urandom);
        f.session_status = 2'($urandom);
        f.tunnel_teid    = $urandom;
      end
      7: begin
        // session lookup that does not allow forwarding
        if ($urandom_range(0, 3) == 0) begin
          f.tunnel_teid = 32'd0;
        end else begin
          f.session_status = 2'($urandom_range(0, 2));
          if (f.session_status == SESSION_ACTIVE) f.session_status = SessionUnlisted;
        end
      end
      8: begin
        // short frame, other ethertype or other ip version
        case ($urandom_range(0, 2))
          0: f.frame_len = 16'($urandom_range(0, 37));
          1: f.ether_type = 16'($urandom);
          default: f.version_ihl[7:4] = 4'($urandom);
        endcase
      end
      9: begin
        // tunnel port right at the edge of the frame
        f.ip_proto = IP_PROTO_UDP;
        ihl = f.version_ihl[3:0];
        f.frame_len = 16'(17 + 4 * ihl + $urandom_range(0, 2));
        if ($urandom_range(0, 1)) f.udp_port_pair[15:0] = GTPU_PORT;
        else f.udp_port_pair[31:16] = GTPU_PORT;
      end
      default: begin
        if (f.ip_proto == IP_PROTO_UDP && $urandom_range(0, 5) == 0)
          f.udp_port_pair[15:0] = GTPU_PORT;
      end
    endcase
    return f;
  endfunction

  function automatic void add_row(in_item_t f, bit typed, verdict_t v, cause_t c);
    directed_rows.push_back('{f, typed, v, c});
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // compare the item just taken from the master side
  function automatic void check_word();
    outer_word_t want;
    if (pending_words.size() == 0) begin
      $display("%0t: unexpected item: expected none actual tdata %h tuser %h tlast %b",
               $time, m_tdata, m_tuser, m_tlast);
      mismatch_count++;
      return;
    end
    want = pending_words.pop_front();
    compare_field("verdict", want.verdict, m_tuser[1:0]);
    compare_field("cause", want.cause, m_tuser[4:2]);
    compare_field("header_word", want.word, m_tdata);
    compare_field("word_index", want.index, m_tuser[7:5]);
    compare_field("last_word", want.last, m_tlast);
  endfunction

  task automatic send_frame(in_item_t f);
    int gap;
    gap = sender_idles ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= InDataWidth'(f);
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // hold the input until every pending result is back, then let it settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic load_registers(logic [15:0] mtu, logic [31:0] source);
    cfg_index <= CFG_LINK_MTU;
    cfg_data  <= {16'($urandom), mtu};
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    egress_mtu_q = mtu;
    cfg_index <= CFG_SOURCE_ADDRESS;
    cfg_data  <= source;
    do @(posedge clk); while (!cfg_ready);
    source_q = source;
    cfg_valid <= 1'b0;
  endtask

  // result sink with random stalls
  initial begin : result_sink
    int gap;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = receiver_idles ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      check_word();
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("gtp_downlink_encapsulator_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    in_item_t    base, f;
    logic [15:0] mtu;
    logic [31:0] src;
    int          phase, n;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_LINK_MTU;
    cfg_data  <= '0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    egress_mtu_q   = '0;
    source_q       = '0;

    base.frame_len       = 16'd100;
    base.ether_type      = ETH_TYPE_IPV4;
    base.version_ihl     = IP_VER_IHL;
    base.ip_proto        = 8'd6;
    base.udp_port_pair   = 32'h1F90_0050;
    base.inner_total_len = 16'd86;
    base.session_status  = SESSION_ACTIVE;
    base.tunnel_teid     = 32'h1234_5678;
    base.peer_address    = 32'h0A00_0001;
    base.flow_id         = 8'd5;
    base.next_hop_mac    = 48'h0200_0000_0001;
    base.own_mac         = 48'h0200_0000_0002;

    // registers at reset: default mtu, no source address
    add_row(base, 1, VERDICT_DROP, CAUSE_NO_SOURCE);
    f = base; f.frame_len = 16'd1471;
    add_row(f, 1, VERDICT_DROP, CAUSE_OVERSIZE);
    // source set, mtu written as zero
    add_row(base, 0, VERDICT_FORWARD, CAUSE_NONE);
    f = base; f.frame_len = 16'd0;
    add_row(f, 1, VERDICT_DROP, CAUSE_SHORT);
    f = base; f.frame_len = 16'd37;
    add_row(f, 1, VERDICT_DROP, CAUSE_SHORT);
    f = base; f.frame_len = MIN_FRAME_LEN;
    add_row(f, 0, VERDICT_FORWARD, CAUSE_NONE);
    f = base; f.ether_type = 16'h86DD;
    add_row(f, 1, VERDICT_PASS, CAUSE_NONE);
    f = base; f.ether_type = 16'hFFFF;
    add_row(f, 1, VERDICT_PASS, CAUSE_NONE);
    f = base; f.version_ihl = 8'h65;
    add_row(f, 1, VERDICT_PASS, CAUSE_NONE);
    // tunnel port with the longest ip header, ports just inside the frame
    f = base; f.ip_proto = IP_PROTO_UDP; f.version_ihl = 8'h4F;
    f.udp_port_pair[15:0] = GTPU_PORT; f.frame_len = 16'd78;
    add_row(f, 1, VERDICT_PASS, CAUSE_ALREADY);
    f = base; f.ip_proto = IP_PROTO_UDP; f.udp_port_pair = {GTPU_PORT, 16'h1234};
    f.frame_len = MIN_FRAME_LEN;
    add_row(f, 1, VERDICT_PASS, CAUSE_ALREADY);
    // ihl below five skips the port check
    f = base; f.ip_proto = IP_PROTO_UDP; f.version_ihl = 8'h44;
    f.udp_port_pair[15:0] = GTPU_PORT;
    add_row(f, 0, VERDICT_FORWARD, CAUSE_NONE);
    // ports one byte past the frame end
    f = base; f.ip_proto = IP_PROTO_UDP; f.version_ihl = 8'h4F;
    f.udp_port_pair[15:0] = GTPU_PORT; f.frame_len = 16'd77;
    add_row(f, 0, VERDICT_FORWARD, CAUSE_NONE);
    f = base; f.udp_port_pair = {GTPU_PORT, GTPU_PORT};
    add_row(f, 0, VERDICT_FORWARD, CAUSE_NONE);
    f = base; f.session_status = SESSION_MISSING;
    add_row(f, 1, VERDICT_DROP, CAUSE_NO_SESSION);
    f = base; f.session_status = SessionInactive;
    add_row(f, 1, VERDICT_DROP, CAUSE_INACTIVE);
    f = base; f.session_status = SessionUnlisted;
    add_row(f, 1, VERDICT_DROP, CAUSE_INACTIVE);
    f = base; f.tunnel_teid = 32'd0;
    add_row(f, 1, VERDICT_DROP, CAUSE_INACTIVE);
    f = base; f.frame_len = 16'd1470;
    add_row(f, 0, VERDICT_FORWARD, CAUSE_NONE);
    f = base; f.frame_len = 16'd1471;
    add_row(f, 1, VERDICT_DROP, CAUSE_OVERSIZE);
    f = base; f.frame_len = 16'hFFFF;
    add_row(f, 1, VERDICT_DROP, CAUSE_OVERSIZE);
    f = base; f.flow_id = 8'd0;
    add_row(f, 0, VERDICT_FORWARD, CAUSE_NONE);
    // all ones, lengths wrap
    f = base; f.flow_id = 8'hFF; f.inner_total_len = 16'hFFFF;
    f.tunnel_teid = 32'hFFFF_FFFF; f.peer_address = 32'hFFFF_FFFF;
    f.next_hop_mac = '1; f.own_mac = '1; f.udp_port_pair = '1; f.ip_proto = 8'hFF;
    add_row(f, 0, VERDICT_FORWARD, CAUSE_NONE);
    f = base; f.inner_total_len = 16'd0; f.peer_address = 32'd0;
    f.next_hop_mac = '0; f.own_mac = '0; f.udp_port_pair = '0; f.ip_proto = 8'd0;
    add_row(f, 0, VERDICT_FORWARD, CAUSE_NONE);

    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[i]) begin
      if (i == ResetRows) begin
        drain_results();
        load_registers(16'd0, 32'hC0A8_0001);
      end
      send_frame(directed_rows[i].frame);
      if (directed_rows[i].typed)
        pending_words.push_back('{directed_rows[i].verdict, directed_rows[i].cause,
                                  64'h0, '0, 1'b1});
      else
        encapsulate_frame(directed_rows[i].frame);
    end

    // random phases under changing register settings
    for (phase = 0; phase < NumPhases; phase++) begin
      drain_results();
      case (phase)
        0: begin mtu = 16'hFFFF; src = 32'hFFFF_FFFF; end
        1: begin mtu = 16'd1; src = $urandom_range(1, 32'hFFFF_FFFF); end
        2: begin mtu = 16'($urandom_range(68, 9000)); src = $urandom; end
        3: begin mtu = 16'd0; src = 32'd1; end
        4: begin mtu = DEFAULT_MTU; src = 32'd0; end
        default: begin mtu = 16'($urandom); src = $urandom; end
      endcase
      sender_idles   = (phase != 1 && phase != 3);
      receiver_idles = (phase != 2 && phase != 3);
      load_registers(mtu, src);
      for (n = 0; n < PhaseItems; n++) begin
        // let the output run dry once in the middle of a phase
        if (phase == 2 && n == PhaseItems / 2) drain_results();
        f = draw_frame();
        send_frame(f);
        encapsulate_frame(f);
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("gtp_downlink_encapsulator_core verification clean");
    end else begin
      $display("gtp_downlink_encapsulator_core verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/gtpde_pkg.sv
rtl/core/gtpde_decide.sv
rtl/core/gtpde_serializer.sv
rtl/core/gtpde_cfg_regs.sv
rtl/core/gtp_downlink_encapsulator_core.sv
rtl/core/gtpde_checker.sv
tb/tb_gtp_downlink_encapsulator_core.sv
